[hdl/fixed_point_alu_macros.svh]
// assertion macros used by the fixed-point alu port checker
`ifndef FIXED_POINT_ALU_MACROS_SVH
`define FIXED_POINT_ALU_MACROS_SVH

// property checked out of reset only
`define FPA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fixed_point_alu check failed");

// property checked at every edge, reset included
`define FPA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fixed_point_alu check failed");

`endif

[hdl/fpa_pkg.sv]
// package with opcodes, status codes and the pipeline item type of the fixed-point alu
package fpa_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;
  localparam int unsigned IN_TDATA_W    = 72;
  localparam int unsigned OUT_TDATA_W   = 40;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_GT  = 4'd4,
    OP_LT  = 4'd5,
    OP_GE  = 4'd6,
    OP_LE  = 4'd7,
    OP_EQ  = 4'd8,
    OP_NE  = 4'd9,
    OP_MIN = 4'd10,
    OP_MAX = 4'd11,
    OP_INC = 4'd12,
    OP_DEC = 4'd13
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_OVF  = 2'd2
  } status_e;

  // item carried down the pipeline
  typedef struct packed {
    op_e         op;
    logic        neg;        // signs of a and b differ
    logic [31:0] simple_val; // result of wrap, min and max modes
    logic        simple_cmp; // result of compare modes
    logic        div0;       // divisor is zero
    logic        div_ovf;    // quotient is 2^32 or more
    logic [31:0] ma;         // magnitude of a
    logic [31:0] d;          // magnitude of b, divisor
    logic [31:0] nlo;        // low half of the shifted dividend
    logic [31:0] rem;        // partial remainder
    logic [31:0] q;          // quotient bits
    logic [63:0] prod;       // product, later rounded magnitude
  } item_t;

endpackage

[hdl/fpa_front.sv]
// operand decode stage: magnitudes, simple ops and divide setup
module fpa_front import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [3:0]  mode_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        ready_o,
  output logic        valid_o,
  output item_t       item_o,
  input  logic        ready_i
);

  logic        valid_q;
  item_t       item_q, item_d;
  logic [31:0] ma, mb;
  logic [63:0] n;
  logic        lt, gt, eq;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // magnitudes and signed compares
  always_comb begin
    ma = a_i[31] ? (32'd0 - a_i) : a_i;
    mb = b_i[31] ? (32'd0 - b_i) : b_i;
    n  = {32'd0, ma} << FRAC_BITS;
    lt = $signed(a_i) < $signed(b_i);
    gt = $signed(a_i) > $signed(b_i);
    eq = a_i == b_i;
  end

  // item fields
  always_comb begin
    item_d            = '0;
    item_d.op         = op_e'(mode_i);
    item_d.neg        = a_i[31] ^ b_i[31];
    item_d.ma         = ma;
    item_d.d          = mb;
    item_d.nlo        = n[31:0];
    item_d.rem        = n[63:32];
    item_d.div0       = (mb == 32'd0);
    item_d.div_ovf    = n >= {mb, 32'd0};
    case (op_e'(mode_i))
      OP_ADD:  item_d.simple_val = a_i + b_i;
      OP_SUB:  item_d.simple_val = a_i - b_i;
      OP_INC:  item_d.simple_val = a_i + 32'd1;
      OP_DEC:  item_d.simple_val = a_i - 32'd1;
      OP_MIN:  item_d.simple_val = lt ? a_i : b_i;
      OP_MAX:  item_d.simple_val = gt ? a_i : b_i;
      OP_GT:   item_d.simple_cmp = gt;
      OP_LT:   item_d.simple_cmp = lt;
      OP_GE:   item_d.simple_cmp = !lt;
      OP_LE:   item_d.simple_cmp = !gt;
      OP_EQ:   item_d.simple_cmp = eq;
      OP_NE:   item_d.simple_cmp = !eq;
      default: item_d.simple_val = 32'd0;
    endcase
  end

  // stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/fpa_mul.sv]
// multiply stage: 32x32 product of the operand magnitudes
module fpa_mul import fpa_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  ready_i
);

  logic        valid_q;
  item_t       item_q, item_d;
  logic [63:0] prod;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // full-width product
  always_comb begin
    prod        = item_i.ma * item_i.d;
    item_d      = item_i;
    item_d.prod = prod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/fpa_div_stage.sv]
// one restoring-division step, resolves a single quotient bit
module fpa_div_stage import fpa_pkg::*; #(
  parameter int unsigned BIT_IDX = 31
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  ready_i
);

  logic        valid_q;
  item_t       item_q, item_d;
  logic [32:0] trial, diff;
  logic        ge;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // shift in the next dividend bit and try the subtract
  always_comb begin
    trial  = {item_i.rem, item_i.nlo[BIT_IDX]};
    diff   = trial - {1'b0, item_i.d};
    ge     = trial >= {1'b0, item_i.d};
    item_d = item_i;
    item_d.rem        = ge ? diff[31:0] : trial[31:0];
    item_d.q[BIT_IDX] = ge;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/fpa_round.sv]
// rounding stage: half-away rounding of product and quotient magnitudes
module fpa_round import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  ready_i
);

  localparam logic [63:0] HALF = (64'd1 << FRAC_BITS) >> 1;

  logic        valid_q;
  item_t       item_q, item_d;
  logic        round_up;
  logic [63:0] qm, pm;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  // pick the rounded magnitude for the opcode
  always_comb begin
    round_up = {item_i.rem, 1'b0} >= {1'b0, item_i.d};
    qm       = {32'd0, item_i.q} + {63'd0, round_up};
    pm       = (item_i.prod + HALF) >> FRAC_BITS;
    item_d   = item_i;
    item_d.prod = (item_i.op == OP_DIV) ? qm : pm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

[hdl/fpa_out.sv]
// output stage: sign, saturation, status and the result register
module fpa_out import fpa_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  item_t                  item_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output logic [OUT_TDATA_W-1:0] data_o,
  input  logic                   ready_i
);

  logic        valid_q;
  logic [34:0] res_q, res_d;
  logic [31:0] val;
  logic        cmp;
  status_e     st;
  logic [63:0] m;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = {{(OUT_TDATA_W - 35){1'b0}}, res_q};

  // final value per opcode
  always_comb begin
    m   = item_i.prod;
    val = 32'd0;
    cmp = 1'b0;
    st  = ST_OK;
    case (item_i.op)
      OP_MUL, OP_DIV: begin
        if (item_i.op == OP_DIV && item_i.div0) begin
          st = ST_DIV0;
        end else if (item_i.neg) begin
          if ((item_i.op == OP_DIV && item_i.div_ovf) || m > 64'h8000_0000) begin
            val = 32'h8000_0000;
            st  = ST_OVF;
          end else begin
            val = 32'd0 - m[31:0];
          end
        end else begin
          if ((item_i.op == OP_DIV && item_i.div_ovf) || m > 64'h7FFF_FFFF) begin
            val = 32'h7FFF_FFFF;
            st  = ST_OVF;
          end else begin
            val = m[31:0];
          end
        end
      end
      OP_GT, OP_LT, OP_GE, OP_LE, OP_EQ, OP_NE: begin
        cmp = item_i.simple_cmp;
      end
      default: begin
        val = item_i.simple_val;
      end
    endcase
    res_d = {st, cmp, val};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      res_q <= res_d;
    end
  end

endmodule

[hdl/fixed_point_alu.sv]
// Signed 32-bit fixed-point alu, pipelined, FRAC_BITS fraction bits.
// Input stream s_axis carries one operation per transfer: opcode and two raw
// two's complement operands. Output stream m_axis carries one result per
// operation, in order: value, compare flag and status.
// From an input transfer to the result being shown, an item passes through:
// decode, multiply, 32 restoring-division steps (one quotient bit each),
// rounding and the output register. Every opcode takes the same path.
// Unstalled throughput is one operation per cycle; division steps set depth.
// Each stage holds its own valid bit, so bubbles close up and s_axis_tready
// stays high while any stage is empty, even when the receiver stalls.
// When m_axis_tready is low the filled stages hold their items; nothing is
// dropped or repeated. With the whole pipe full, s_axis_tready then goes low.
// Reset (rst_ni low) clears every valid bit; the pipe starts empty.
// Divide by zero gives value 0 and status 1; multiply and divide saturate
// with status 2; undefined opcodes give all zeros.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // mode[3:0], operand_a[35:4], operand_b[67:36], zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // result_value[31:0], compare_true[32], status[34:33], zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned NDIV = 32;

  logic          fr_valid, fr_ready;
  item_t         fr_item;
  logic          dv_valid [NDIV+1];
  logic          dv_ready [NDIV+1];
  item_t         dv_item  [NDIV+1];
  logic          rd_valid, rd_ready;
  item_t         rd_item;

  // operand decode
  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .mode_i  (s_axis_tdata[3:0]),
    .a_i     (s_axis_tdata[35:4]),
    .b_i     (s_axis_tdata[67:36]),
    .ready_o (s_axis_tready),
    .valid_o (fr_valid),
    .item_o  (fr_item),
    .ready_i (fr_ready)
  );

  // product
  fpa_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr_valid),
    .item_i  (fr_item),
    .ready_o (fr_ready),
    .valid_o (dv_valid[0]),
    .item_o  (dv_item[0]),
    .ready_i (dv_ready[0])
  );

  // division steps, most significant quotient bit first
  for (genvar k = 0; k < NDIV; k++) begin : g_div
    fpa_div_stage #(.BIT_IDX(NDIV - 1 - k)) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[k]),
      .item_i  (dv_item[k]),
      .ready_o (dv_ready[k]),
      .valid_o (dv_valid[k+1]),
      .item_o  (dv_item[k+1]),
      .ready_i (dv_ready[k+1])
    );
  end

  // rounding
  fpa_round #(.FRAC_BITS(FRAC_BITS)) u_round (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dv_valid[NDIV]),
    .item_i  (dv_item[NDIV]),
    .ready_o (dv_ready[NDIV]),
    .valid_o (rd_valid),
    .item_o  (rd_item),
    .ready_i (rd_ready)
  );

  // saturation and result register
  fpa_out u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rd_valid),
    .item_i  (rd_item),
    .ready_o (rd_ready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .ready_i (m_axis_tready)
  );

endmodule

[hdl/fpa_checker.sv]
// port-level checker for the fixed-point alu and its bind
`include "fixed_point_alu_macros.svh"

module fpa_checker import fpa_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // a stalled result holds
  `FPA_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

  // a true compare comes with zero value and ok status
  `FPA_ASSERT(a_cmp_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0 && m_axis_tdata[34:33] == ST_OK)

  // divide by zero gives zero value
  `FPA_ASSERT(a_div0_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[34:33] == ST_DIV0 |-> m_axis_tdata[31:0] == 32'd0 && !m_axis_tdata[32])

  // saturation only to the two range limits
  `FPA_ASSERT(a_ovf_limit, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[34:33] == ST_OVF |-> m_axis_tdata[31:0] == 32'h7FFF_FFFF || m_axis_tdata[31:0] == 32'h8000_0000)

  // no result during reset
  `FPA_ASSERT_ALWAYS(a_rst_idle, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/fixed_point_alu_checker.sv]
// checker for the fixed-point alu: predicts each result and compares it in order
module fixed_point_alu_checker import fpa_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  input  logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  input  logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                     fail_count_o,
  output int                     pending_o
);

  // laid out as on m_axis_tdata, value in the lowest bits
  typedef struct packed {
    logic [1:0]  status;
    logic        flag;
    logic [31:0] value;
  } alu_result_t;

  alu_result_t result_q[$];
  int mismatches;

  // saturate a signed magnitude into 32 bits
  function automatic void saturate(input logic [63:0] m, input logic neg,
                                   inout alu_result_t r);
    if (neg) begin
      if (m > 64'h8000_0000) begin
        r.value = 32'h8000_0000;
        r.status = ST_OVF;
      end else begin
        r.value = 32'(64'd0 - m);
      end
    end else if (m > 64'h7FFF_FFFF) begin
      r.value = 32'h7FFF_FFFF;
      r.status = ST_OVF;
    end else begin
      r.value = m[31:0];
    end
  endfunction

  function automatic alu_result_t compute_alu(input logic [3:0] op,
                                              input logic [31:0] ua,
                                              input logic [31:0] ub);
    alu_result_t r;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic [63:0] ma;
    logic [63:0] mb;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] rm;
    logic neg;
    r = '0;
    a = ua;
    b = ub;
    ma = a[31] ? 64'd0 - {{32{1'b1}}, ua} : {32'd0, ua};
    mb = b[31] ? 64'd0 - {{32{1'b1}}, ub} : {32'd0, ub};
    neg = a[31] ^ b[31];
    case (op)
      OP_ADD: r.value = ua + ub;
      OP_SUB: r.value = ua - ub;
      OP_MUL: begin
        p = ma * mb;
        if (FRAC_BITS > 0) p = p + (64'd1 << (FRAC_BITS - 1));
        saturate(p >> FRAC_BITS, neg, r);
      end
      OP_DIV: begin
        if (mb == 0) begin
          r.status = ST_DIV0;
        end else begin
          p = ma << FRAC_BITS;
          q = p / mb;
          rm = p % mb;
          if (2 * rm >= mb) q = q + 1;
          saturate(q, neg, r);
        end
      end
      OP_GT:  r.flag = a > b;
      OP_LT:  r.flag = a < b;
      OP_GE:  r.flag = a >= b;
      OP_LE:  r.flag = a <= b;
      OP_EQ:  r.flag = a == b;
      OP_NE:  r.flag = a != b;
      OP_MIN: r.value = (a < b) ? ua : ub;
      OP_MAX: r.value = (a > b) ? ua : ub;
      OP_INC: r.value = ua + 32'd1;
      OP_DEC: r.value = ua - 32'd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  assign pending_o = result_q.size();
  assign fail_count_o = mismatches;

  // record expectations and compare results at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    alu_result_t got;
    alu_result_t exp_r;
    if (!rst_ni) begin
      result_q.delete();
      mismatches <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(compute_alu(s_axis_tdata[3:0], s_axis_tdata[35:4],
                                       s_axis_tdata[67:36]));
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[34:0];
        if (result_q.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", got);
        end else begin
          exp_r = result_q.pop_front();
          if (got.value !== exp_r.value || got.flag !== exp_r.flag ||
              got.status !== exp_r.status) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display("mismatch: expected val %h cmp %b st %0d, got val %h cmp %b st %0d",
                       exp_r.value, exp_r.flag, exp_r.status,
                       got.value, got.flag, got.status);
          end
        end
      end
    end
  end

endmodule

[bench/fixed_point_alu_tb.sv]
// testbench top for the fixed-point alu: stimulus, stalls and verdict
module fixed_point_alu_tb;
  import fpa_pkg::*;

  localparam int RandomOps  = 1200;
  localparam int IdleLimit  = 5000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  bit hold_off = 1'b0;

  always #5 clk_i = ~clk_i;

  fixed_point_alu u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  fixed_point_alu_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver stall pattern, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_off) m_axis_tready <= 1'b0;
    else case ($urandom_range(0, 3))
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= $urandom_range(0, 1);
    endcase
  end

  initial begin
    hold_off = 1'b0;
    wait (rst_ni);
    repeat (400) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (120) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // one transfer, held until accepted
  task automatic send_op(input logic [3:0] op, input logic [31:0] a,
                         input logic [31:0] b);
    s_axis_tdata <= {4'd0, b, a, op};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000 + $urandom_range(0, 2);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      2: return $urandom_range(0, 4);
      3: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      4: return 32'($signed($urandom_range(0, 4096)) - 2048);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] corner [6];
    int burst;
    corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd256, 32'd1};
    // reset edge after time zero so every flop sees it
    #1 rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: every opcode including undefined, extremes and zero divisor
    for (int op = 0; op < 16; op++) send_op(op[3:0], corner[op % 6], corner[(op + 1) % 6]);
    send_op(OP_DIV, 32'd5, 32'd0);
    send_op(OP_DIV, 32'h8000_0000, 32'd1);
    send_op(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_op(OP_MUL, 32'h8000_0000, 32'h0000_0100);
    send_op(OP_DIV, 32'd3, 32'd2048);
    send_op(OP_MIN, 32'd7, 32'd7);
    send_op(OP_INC, 32'h7FFF_FFFF, 32'd0);
    send_op(OP_DEC, 32'h8000_0000, 32'd0);
    // random bursts; sender pauses until drained once midway
    for (int i = 0; i < RandomOps;) begin
      burst = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 20);
      for (int k = 0; k < burst && i < RandomOps; k++, i++)
        send_op(($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 13)),
                pick_operand(), pick_operand());
      s_axis_tvalid <= 1'b0;
      if (i >= RandomOps / 2 && i - burst < RandomOps / 2) begin
        wait (pending == 0);
        @(negedge clk_i);
      end else repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
